// ===== sv/srt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and the 5x7 column font for the text rasterizer.
// No dependencies; every other file of the block imports this package.
package srt_pkg;

    // Field widths
    localparam int COORD_W  = 10;
    localparam int CUR_W    = 11;
    localparam int EXT_W    = 12;   // cursor or row plus a few dot offsets
    localparam int CODE_W   = 8;
    localparam int COLOR_W  = 16;
    localparam int SCALE_W  = 4;
    localparam int RECT_W   = 9;

    // Font geometry
    localparam int COLS     = 5;
    localparam int ROWS     = 7;
    localparam int CELLS    = COLS * ROWS;
    localparam int ADVANCE  = 6;
    localparam int ROW_W    = 3;

    // Job queue between front and back
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);

    // Configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic       REG_WIDTH_LIMIT   = 1'b0;
    localparam logic [9:0] WIDTH_LIMIT_RESET = 10'd320;

    // Character codes
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_PERCENT  = 8'h25;

    typedef logic [CELLS-1:0] t_glyph;

    typedef struct packed {
        logic                 first_of_string;
        logic [COORD_W-1:0]   start_x;
        logic [COORD_W-1:0]   start_y;
        logic [CODE_W-1:0]    char_code;
        logic [COLOR_W-1:0]   pixel_color;
        logic [SCALE_W-1:0]   scale;
    } t_char_item;

    typedef struct packed {
        logic [RECT_W-1:0]    rect_x;
        logic [RECT_W-1:0]    rect_y;
        logic [SCALE_W-1:0]   rect_w;
        logic [SCALE_W-1:0]   rect_h;
        logic [COLOR_W-1:0]   rect_color;
        logic                 last_of_char;
    } t_rect_item;

    // One character's drawing job: visible dots only, column-major, bit 0 first
    typedef struct packed {
        logic [CUR_W-1:0]     x;
        logic [COORD_W-1:0]   y;
        logic [SCALE_W-1:0]   scale;
        logic [COLOR_W-1:0]   color;
        t_glyph               mask;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Pack five column bytes into one word, column 0 in the low bits
    function automatic t_glyph glyph5(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3,
                                      input logic [7:0] b4);
        return {b4[6:0], b3[6:0], b2[6:0], b1[6:0], b0[6:0]};
    endfunction

    localparam t_glyph FONT_FALLBACK = glyph5(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);
    localparam t_glyph FONT_BLANK    = glyph5(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    localparam t_glyph FONT_DASH     = glyph5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
    localparam t_glyph FONT_DOT      = glyph5(8'h00, 8'h00, 8'h00, 8'h60, 8'h60);
    localparam t_glyph FONT_COLON    = glyph5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
    localparam t_glyph FONT_SLASH    = glyph5(8'h40, 8'h30, 8'h08, 8'h06, 8'h01);
    localparam t_glyph FONT_PERCENT  = glyph5(8'h63, 8'h13, 8'h08, 8'h64, 8'h63);

    localparam t_glyph FONT_DIGITS [10] = '{
        glyph5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E), glyph5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00),
        glyph5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46), glyph5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31),
        glyph5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10), glyph5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39),
        glyph5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30), glyph5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03),
        glyph5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36), glyph5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E)
    };

    localparam t_glyph FONT_LETTERS [26] = '{
        glyph5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E), glyph5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36),
        glyph5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22), glyph5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C),
        glyph5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41), glyph5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01),
        glyph5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A), glyph5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F),
        glyph5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00), glyph5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01),
        glyph5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41), glyph5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40),
        glyph5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F), glyph5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F),
        glyph5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E), glyph5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06),
        glyph5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E), glyph5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46),
        glyph5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31), glyph5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01),
        glyph5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F), glyph5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F),
        glyph5(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F), glyph5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63),
        glyph5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07), glyph5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43)
    };

    // Map a raw byte to its glyph: fold lower case, out-of-range to '?'
    function automatic t_glyph glyph_bits(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] c;
        t_glyph            g;
        c = code;
        if (c > CH_TILDE) c = CH_QMARK;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_OFFSET;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            g = FONT_DIGITS[4'(c - CH_ZERO)];
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            g = FONT_LETTERS[5'(c - CH_UPPER_A)];
        end else begin
            case (c)
                CH_SPACE:   g = FONT_BLANK;
                CH_DASH:    g = FONT_DASH;
                CH_DOT:     g = FONT_DOT;
                CH_COLON:   g = FONT_COLON;
                CH_SLASH:   g = FONT_SLASH;
                CH_PERCENT: g = FONT_PERCENT;
                default:    g = FONT_FALLBACK;
            endcase
        end
        return g;
    endfunction

endpackage
`default_nettype wire

// ===== sv/scaled_font_text_rasterizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the scaled 5x7 text rasterizer: config port, front, queue, back.
// Depends on srt_pkg, srt_front, srt_queue and srt_back.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_in_item  (t_char_item)
//   output    out        o_out_valid / i_out_stall o_out_item (t_rect_item)
//   config    in         psel, penable, pwrite     paddr, pwdata, prdata
//
// A character item is taken by the front end, which updates the cursor and
// stopped flag at once and queues a job holding only its visible dots. The
// back end scans that job one glyph cell a cycle, column by column, holding
// on a set dot while the output stalls, and stops after the last visible
// dot. Characters that show nothing queue no job.
// The input stalls only while the two-entry queue is full; the output
// register holds a square under stall and freezes the scan on a set dot.
// Reset clears cursor, stopped flag, queue and output, and sets
// width_limit to 320.
module scaled_font_text_rasterizer_core
    import srt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 480
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_char_item           i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_rect_item                o_out_item,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    logic [9:0] r_width_limit;
    logic       reg_sel;
    logic       in_accept;
    logic       push, pop;
    t_job       front_job, q_job;
    t_q_status  q_status;

    // Register decode: word index is the top address bit, low bits ignored
    assign reg_sel = (paddr[PADDR_W-1] == REG_WIDTH_LIMIT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? PDATA_W'(r_width_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_limit <= WIDTH_LIMIT_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_width_limit <= pwdata[9:0];
        end
    end

    // Hold input only while the job queue is full
    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    srt_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_item       (i_in_item),
        .i_width_limit(r_width_limit),
        .o_push       (push),
        .o_job        (front_job)
    );

    srt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_status(q_status)
    );

    srt_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_job),
        .i_q_status (q_status),
        .o_pop      (pop),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item)
    );

endmodule
`default_nettype wire

// ===== sv/srt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts characters, keeps cursor and stopped flag, builds jobs.
// Depends on srt_pkg (item and job types, font lookup).
module srt_front
    import srt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 480
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire t_char_item   i_item,
    input  wire logic [9:0]   i_width_limit,
    output logic              o_push,
    output t_job              o_job
);

    logic [CUR_W-1:0] r_cursor, n_cursor;
    logic             r_stopped, n_stopped;

    logic [CUR_W-1:0] cur_eff;
    logic             stop_eff;
    logic [EXT_W-1:0] scale_ext;
    logic [EXT_W-1:0] fit_sum;
    logic             draw;
    logic [COLS-1:0]  col_ok;
    logic [ROWS-1:0]  row_ok;
    t_glyph           glyph;
    t_glyph           vis;

    always_comb begin
        cur_eff   = i_item.first_of_string ? CUR_W'(i_item.start_x) : r_cursor;
        stop_eff  = i_item.first_of_string ? 1'b0 : r_stopped;
        scale_ext = EXT_W'(i_item.scale);
        fit_sum   = EXT_W'(cur_eff) + EXT_W'(COLS) * scale_ext;
        draw      = !stop_eff && (fit_sum <= EXT_W'(i_width_limit));
        glyph     = glyph_bits(i_item.char_code);

        // Columns and rows whose dot starts on screen
        for (int c = 0; c < COLS; c++) begin
            col_ok[c] = (EXT_W'(cur_eff) + EXT_W'(c) * scale_ext) < EXT_W'(SCREEN_WIDTH);
        end
        for (int r = 0; r < ROWS; r++) begin
            row_ok[r] = (EXT_W'(i_item.start_y) + EXT_W'(r) * scale_ext)
                        < EXT_W'(SCREEN_HEIGHT);
        end
        for (int c = 0; c < COLS; c++) begin
            for (int r = 0; r < ROWS; r++) begin
                vis[c*ROWS + r] = glyph[c*ROWS + r] && col_ok[c] && row_ok[r]
                                  && (i_item.scale != '0);
            end
        end

        n_cursor  = r_cursor;
        n_stopped = r_stopped;
        if (i_accept) begin
            n_stopped = !draw;
            n_cursor  = draw ? CUR_W'(EXT_W'(cur_eff) + EXT_W'(ADVANCE) * scale_ext)
                             : cur_eff;
        end

        o_push      = i_accept && draw && (vis != '0);
        o_job.x     = cur_eff;
        o_job.y     = i_item.start_y;
        o_job.scale = i_item.scale;
        o_job.color = i_item.pixel_color;
        o_job.mask  = vis;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_cursor  <= n_cursor;
            r_stopped <= n_stopped;
        end
    end

endmodule
`default_nettype wire

// ===== sv/srt_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Short job queue that decouples the front end from the square scanner.
// Depends on srt_pkg (job and status types, depth).
module srt_queue
    import srt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_job   i_job,
    input  wire logic   i_pop,
    output t_job        o_job,
    output t_q_status   o_status
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/srt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Back end: walks a job's cells one a cycle (a set dot waits out an output stall) and emits squares.
// Depends on srt_pkg (job, status and result types).
module srt_back
    import srt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 480
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_job       i_job,
    input  wire t_q_status  i_q_status,
    output logic            o_pop,
    input  wire logic       i_out_stall,
    output logic            o_out_valid,
    output t_rect_item      o_out_item
);

    t_glyph             r_mask, n_mask;
    logic [EXT_W-1:0]   r_x, n_x;
    logic [EXT_W-1:0]   r_y, n_y;
    logic [COORD_W-1:0] r_ybase, n_ybase;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [SCALE_W-1:0] r_scale, n_scale;
    logic [COLOR_W-1:0] r_color, n_color;
    logic               r_out_valid, n_out_valid;
    t_rect_item         r_out, n_out;

    logic               busy, slot_free, emit, advance;
    logic [EXT_W-1:0]   x_left, y_left;

    always_comb begin
        busy      = (r_mask != '0);
        slot_free = !r_out_valid || !i_out_stall;
        emit      = busy && r_mask[0] && slot_free;
        advance   = busy && (!r_mask[0] || slot_free);
        o_pop     = !busy && !i_q_status.empty;
        x_left    = EXT_W'(SCREEN_WIDTH) - r_x;
        y_left    = EXT_W'(SCREEN_HEIGHT) - r_y;

        n_mask  = r_mask;
        n_x     = r_x;
        n_y     = r_y;
        n_ybase = r_ybase;
        n_row   = r_row;
        n_scale = r_scale;
        n_color = r_color;

        if (o_pop) begin
            n_mask  = i_job.mask;
            n_x     = EXT_W'(i_job.x);
            n_y     = EXT_W'(i_job.y);
            n_ybase = i_job.y;
            n_row   = '0;
            n_scale = i_job.scale;
            n_color = i_job.color;
        end else if (advance) begin
            n_mask = r_mask >> 1;
            if (r_row == ROW_W'(ROWS - 1)) begin
                n_row = '0;
                n_x   = r_x + EXT_W'(r_scale);
                n_y   = EXT_W'(r_ybase);
            end else begin
                n_row = r_row + 1'b1;
                n_y   = r_y + EXT_W'(r_scale);
            end
        end

        n_out_valid = slot_free ? emit : r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out.rect_x       = r_x[RECT_W-1:0];
            n_out.rect_y       = r_y[RECT_W-1:0];
            n_out.rect_w       = (x_left < EXT_W'(r_scale)) ? x_left[SCALE_W-1:0] : r_scale;
            n_out.rect_h       = (y_left < EXT_W'(r_scale)) ? y_left[SCALE_W-1:0] : r_scale;
            n_out.rect_color   = r_color;
            n_out.last_of_char = (r_mask[CELLS-1:1] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_ybase <= n_ybase;
        r_row   <= n_row;
        r_scale <= n_scale;
        r_color <= n_color;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ===== sv/srt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the rasterizer output, bound to the top level.
// Depends on srt_pkg (result type) and scaled_font_text_rasterizer_core.
module srt_checker
    import srt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 480
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire t_rect_item o_out_item
);

    // Hold a stalled square
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("output square changed under stall");

    // Clipped squares are never empty
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.rect_w != '0) && (o_out_item.rect_h != '0))
        else $error("empty square emitted");

    // Clipping keeps a square inside the screen where coordinates fit
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((SCREEN_WIDTH > 512) ||
             (EXT_W'(o_out_item.rect_x) + EXT_W'(o_out_item.rect_w)
              <= EXT_W'(SCREEN_WIDTH))) &&
            ((SCREEN_HEIGHT > 512) ||
             (EXT_W'(o_out_item.rect_y) + EXT_W'(o_out_item.rect_h)
              <= EXT_W'(SCREEN_HEIGHT))))
        else $error("square extends past the screen edge");

endmodule

bind scaled_font_text_rasterizer_core srt_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_srt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
`default_nettype wire

// ===== dv/tb_scaled_font_text_rasterizer_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for scaled_font_text_rasterizer_core: a directed table of characters,
// then random strings, each square checked against an in-bench glyph rasteriser.
// Depends on srt_pkg and the rasterizer RTL only.
module tb_scaled_font_text_rasterizer_core
    import srt_pkg::*;
();

    localparam int SCREEN_W     = 320;
    localparam int SCREEN_H     = 480;
    localparam int DRAIN_CYCLES = 120;   // two queued jobs plus one in the scan, with margin
    localparam int ITEM_BITS    = $bits(t_char_item);
    localparam int N_DIRECTED   = 25;
    localparam int N_PHASES     = 5;
    localparam int PHASE_ITEMS  = 36;
    localparam logic [PADDR_W-1:0] MARGIN_ADDR = PADDR_W'(4 * REG_WIDTH_LIMIT);

    // Column bytes, column 0 in the top byte; bit 0 of a byte is the top row
    localparam logic [10*40-1:0] DIGIT_FONT = {
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31, 40'h1814127F10,
        40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936, 40'h064949291E};
    localparam logic [26*40-1:0] LETTER_FONT = {
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C, 40'h7F49494941,
        40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
        40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
        40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463, 40'h0708700807,
        40'h6151494543};
    localparam logic [39:0] GLYPH_FALLBACK = 40'h0201510906;

    typedef enum {PACE_FREE, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} t_pace;

    // One row of the directed table: an optional margin write before the character, and
    // where the outcome is obvious, the square count and the final square typed in.
    typedef struct packed {
        logic       set_margin;
        logic [9:0] margin;
        t_char_item ch;
        logic       typed;
        logic [5:0] n_sq;
        t_rect_item last_sq;
    } t_dir_row;

    localparam t_rect_item NO_SQ = '0;

    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        // straight after reset: pen at 0, margin 320, start_x ignored on a non-first item
        '{1'b0, 10'd0, '{1'b0, 10'd5, 10'd0, "I", 16'hFFFF, 4'd1},
          1'b1, 6'd11, '{9'd3, 9'd6, 4'd1, 4'd1, 16'hFFFF, 1'b1}},
        // lower case folds to upper case, pen has moved on by six
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd10, "i", 16'h0000, 4'd1},
          1'b1, 6'd11, '{9'd9, 9'd16, 4'd1, 4'd1, 16'h0000, 1'b1}},
        // zero byte, codes above the tilde and the tilde itself: fallback glyph
        '{1'b0, 10'd0, '{1'b1, 10'd0, 10'd0, 8'h00, 16'h1234, 4'd1}, 1'b0, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd0, 8'hFF, 16'h5555, 4'd2}, 1'b0, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd0, 8'h7E, 16'hAAAA, 4'd1}, 1'b0, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd0, 8'h7F, 16'h0F0F, 4'd3}, 1'b0, 6'd0, NO_SQ},
        // blank glyph draws nothing but still advances
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd0, " ", 16'hFFFF, 4'd1}, 1'b1, 6'd0, NO_SQ},
        // every punctuation glyph, then a digit
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd40, "-", 16'h0001, 4'd2}, 1'b0, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd40, ".", 16'h0002, 4'd1}, 1'b0, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd40, ":", 16'h0004, 4'd4}, 1'b0, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd40, "/", 16'h0008, 4'd1}, 1'b0, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd40, "%", 16'h0010, 4'd2}, 1'b0, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd40, "0", 16'h0020, 4'd1}, 1'b0, 6'd0, NO_SQ},
        // scale zero: no squares, pen stays put
        '{1'b0, 10'd0, '{1'b1, 10'd0, 10'd200, "A", 16'hFFFF, 4'd0}, 1'b1, 6'd0, NO_SQ},
        // largest scale, squares fifteen wide
        '{1'b0, 10'd0, '{1'b1, 10'd0, 10'd0, "H", 16'hA5A5, 4'd15}, 1'b0, 6'd0, NO_SQ},
        // past the margin: stop, and stay stopped although the next one would fit
        '{1'b0, 10'd0, '{1'b1, 10'd300, 10'd0, "A", 16'hFFFF, 4'd8}, 1'b1, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd0, "A", 16'hFFFF, 4'd1}, 1'b1, 6'd0, NO_SQ},
        // exactly on the margin still draws; the next character then stops the string
        '{1'b0, 10'd0, '{1'b1, 10'd315, 10'd0, "H", 16'h00FF, 4'd1},
          1'b1, 6'd17, '{9'd319, 9'd6, 4'd1, 4'd1, 16'h00FF, 1'b1}},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd0, "A", 16'h00FF, 4'd1}, 1'b1, 6'd0, NO_SQ},
        // widest margin: square clipped to one column at the right screen edge
        '{1'b1, 10'd1023, '{1'b1, 10'd319, 10'd0, "-", 16'h8001, 4'd8},
          1'b1, 6'd1, '{9'd319, 9'd24, 4'd1, 4'd8, 16'h8001, 1'b1}},
        // bottom screen row: only the top row of the fallback glyph survives, one high
        '{1'b0, 10'd0, '{1'b1, 10'd0, 10'd479, 8'h00, 16'h7FFE, 4'd2},
          1'b1, 6'd3, '{9'd6, 9'd479, 4'd2, 4'd1, 16'h7FFE, 1'b1}},
        // field extremes: over the margin, and drawn but wholly off screen
        '{1'b0, 10'd0, '{1'b1, 10'd1023, 10'd1023, "A", 16'hFFFF, 4'd1}, 1'b1, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b1, 10'd983, 10'd1023, "W", 16'hFFFF, 4'd8}, 1'b1, 6'd0, NO_SQ},
        // zero margin: only a scale-zero character at column 0 passes, and shows nothing
        '{1'b1, 10'd0, '{1'b1, 10'd0, 10'd0, "A", 16'hFFFF, 4'd0}, 1'b1, 6'd0, NO_SQ},
        '{1'b0, 10'd0, '{1'b0, 10'd0, 10'd0, "A", 16'hFFFF, 4'd1}, 1'b1, 6'd0, NO_SQ}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_char_item           in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_rect_item           out_item;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Rasteriser state mirrored in the bench
    logic [CUR_W-1:0] pen_x = '0;
    logic             line_halted = 1'b0;
    logic [9:0]       right_margin = 10'd320;   // value expected straight after reset

    t_rect_item squares_due [$];
    int gap_pct = 0;
    int stall_pct = 0;
    int n_errors = 0;
    int n_chars = 0;
    int n_squares = 0;
    int n_settings = 0;

    scaled_font_text_rasterizer_core #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 clk = ~clk;

    task automatic set_pace(input t_pace p);
        case (p)
            PACE_FREE: begin
                gap_pct = 0;
                stall_pct = 0;
            end
            PACE_SRC_IDLE: begin
                gap_pct = 83;
                stall_pct = 0;
            end
            PACE_SINK_STALL: begin
                gap_pct = 0;
                stall_pct = 83;
            end
            default: begin
                gap_pct = 9;
                stall_pct = 9;
            end
        endcase
    endtask

    // Drop valid, wait for every square owed, then idle for DRAIN_CYCLES as a margin
    task automatic settle();
        in_valid <= 1'b0;
        while (squares_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Optionally write width_limit, then read it back; only called while the block is idle
    task automatic program_margin(input bit wr, input logic [9:0] value);
        if (wr) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= MARGIN_ADDR;
            pwdata <= PDATA_W'(value);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            right_margin = value;
            n_settings++;
        end
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= MARGIN_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== PDATA_W'(right_margin)) begin
            $error("width_limit: expected %0d, got %0d", right_margin, prdata);
            n_errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one character, hold it until taken, then rasterise it into the queue of
    // squares owed. A typed row replaces the count and the final square with its own.
    task automatic send_char(input t_char_item ch, input bit typed, input int typed_n,
                             input t_rect_item typed_last);
        t_rect_item  sq [35];
        t_rect_item  due;
        logic [39:0] glyph;
        logic [7:0]  c;
        logic [7:0]  col_bits;
        int          n;
        int          x;
        int          y;
        int          idx;
        int          want;
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= ch;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_chars++;

        if (ch.first_of_string) begin
            pen_x = CUR_W'(ch.start_x);
            line_halted = 1'b0;
        end
        n = 0;
        if (!line_halted) begin
            if (pen_x + 5 * ch.scale > right_margin) begin
                line_halted = 1'b1;
            end else begin
                // fold the code: out of range becomes a question mark, lower to upper
                c = ch.char_code;
                if (c > CH_TILDE) c = CH_QMARK;
                if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_OFFSET;
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    idx = int'(c - CH_ZERO);
                    glyph = DIGIT_FONT[(9 - idx) * 40 +: 40];
                end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                    idx = int'(c - CH_UPPER_A);
                    glyph = LETTER_FONT[(25 - idx) * 40 +: 40];
                end else begin
                    case (c)
                        CH_SPACE:   glyph = 40'h0000000000;
                        CH_DASH:    glyph = 40'h0808080808;
                        CH_DOT:     glyph = 40'h0000006060;
                        CH_COLON:   glyph = 40'h0036360000;
                        CH_SLASH:   glyph = 40'h4030080601;
                        CH_PERCENT: glyph = 40'h6313086463;
                        default:    glyph = GLYPH_FALLBACK;
                    endcase
                end
                // column-major scan, skip squares whose corner falls off screen
                if (ch.scale != 0) begin
                    for (int col = 0; col < 5; col++) begin
                        col_bits = glyph[39 - 8 * col -: 8];
                        for (int row = 0; row < 7; row++) begin
                            x = int'(pen_x) + col * int'(ch.scale);
                            y = int'(ch.start_y) + row * int'(ch.scale);
                            if (col_bits[row] && x < SCREEN_W && y < SCREEN_H) begin
                                sq[n].rect_x = 9'(x);
                                sq[n].rect_y = 9'(y);
                                sq[n].rect_w = (int'(ch.scale) < SCREEN_W - x) ?
                                               ch.scale : 4'(SCREEN_W - x);
                                sq[n].rect_h = (int'(ch.scale) < SCREEN_H - y) ?
                                               ch.scale : 4'(SCREEN_H - y);
                                sq[n].rect_color = ch.pixel_color;
                                sq[n].last_of_char = 1'b0;
                                n++;
                            end
                        end
                    end
                end
                if (n > 0) sq[n - 1].last_of_char = 1'b1;
                pen_x = pen_x + CUR_W'(6 * int'(ch.scale));
            end
        end

        want = typed ? typed_n : n;
        for (int i = 0; i < want; i++) begin
            due = (typed && i == want - 1) ? typed_last : sq[i];
            squares_due = {squares_due, due};
        end
    endtask

    // Square sink: check each accepted square against the oldest one owed, then pick
    // the stall for the next cycle.
    always @(posedge clk) begin : square_sink
        t_rect_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_squares++;
                if (squares_due.size() == 0) begin
                    $error("square at x=%0d y=%0d with none owed",
                           out_item.rect_x, out_item.rect_y);
                    n_errors++;
                end else begin
                    want = squares_due.pop_front();
                    if (out_item.rect_x !== want.rect_x) begin
                        $error("rect_x: expected %0d, got %0d", want.rect_x, out_item.rect_x);
                        n_errors++;
                    end
                    if (out_item.rect_y !== want.rect_y) begin
                        $error("rect_y: expected %0d, got %0d", want.rect_y, out_item.rect_y);
                        n_errors++;
                    end
                    if (out_item.rect_w !== want.rect_w) begin
                        $error("rect_w: expected %0d, got %0d", want.rect_w, out_item.rect_w);
                        n_errors++;
                    end
                    if (out_item.rect_h !== want.rect_h) begin
                        $error("rect_h: expected %0d, got %0d", want.rect_h, out_item.rect_h);
                        n_errors++;
                    end
                    if (out_item.rect_color !== want.rect_color) begin
                        $error("rect_color: expected %h, got %h",
                               want.rect_color, out_item.rect_color);
                        n_errors++;
                    end
                    if (out_item.last_of_char !== want.last_of_char) begin
                        $error("last_of_char: expected %0d, got %0d",
                               want.last_of_char, out_item.last_of_char);
                        n_errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        t_char_item ch;
        int         phase_items;
        int         len;
        logic [9:0] sx;
        logic [9:0] sy;
        logic [3:0] sc;
        logic [15:0] color;
        logic [9:0] margin;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // width_limit must read back its reset value
        program_margin(1'b0, 10'd0);

        // Directed table, no idling; margin writes only once the block has drained
        set_pace(PACE_FREE);
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].set_margin) begin
                settle();
                program_margin(1'b1, DIRECTED[i].margin);
            end
            send_char(DIRECTED[i].ch, DIRECTED[i].typed, int'(DIRECTED[i].n_sq),
                      DIRECTED[i].last_sq);
        end

        // Random strings: one margin and one pacing per phase, the last phase mixes pacing
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0:       margin = 10'd320;
                1:       margin = 10'd1023;
                2:       margin = 10'($urandom_range(40, 1022));
                3:       margin = 10'd160;
                default: margin = 10'd1023;
            endcase
            program_margin(1'b1, margin);
            set_pace(t_pace'(p < 4 ? p : 0));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                len = $urandom_range(1, 10);
                if (p == 4) set_pace(t_pace'($urandom_range(0, 3)));
                // now and then hold off until the block has delivered everything
                if ($urandom_range(7) == 0) settle();
                sx = ($urandom_range(7) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, 260));
                sy = ($urandom_range(7) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, 470));
                sc = ($urandom_range(9) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, 4));
                color = 16'($urandom);
                for (int k = 0; k < len; k++) begin
                    ch.first_of_string = (k == 0);
                    ch.start_x = sx;
                    ch.start_y = sy;
                    ch.scale = sc;
                    ch.pixel_color = color;
                    case ($urandom_range(0, 9))
                        0, 1, 2: ch.char_code = CH_UPPER_A + 8'($urandom_range(0, 25));
                        3, 4:    ch.char_code = CH_LOWER_A + 8'($urandom_range(0, 25));
                        5, 6:    ch.char_code = CH_ZERO + 8'($urandom_range(0, 9));
                        7: begin
                            case ($urandom_range(0, 5))
                                0:       ch.char_code = CH_SPACE;
                                1:       ch.char_code = CH_DASH;
                                2:       ch.char_code = CH_DOT;
                                3:       ch.char_code = CH_COLON;
                                4:       ch.char_code = CH_SLASH;
                                default: ch.char_code = CH_PERCENT;
                            endcase
                        end
                        default: ch.char_code = 8'($urandom_range(0, 255));
                    endcase
                    // noise: a wholly random item breaks the string now and then
                    if ($urandom_range(9) == 0) ch = ITEM_BITS'({$urandom, $urandom});
                    send_char(ch, 1'b0, 0, NO_SQ);
                    phase_items++;
                end
            end
        end

        settle();
        $display("Drove %0d characters (%0d from the directed table) across %0d margin writes,",
                 n_chars, N_DIRECTED, n_settings);
        $display("all pacing modes and stopped strings; %0d squares compared.", n_squares);
        if (n_errors == 0) begin
            $display("scaled_font_text_rasterizer_core test passed");
        end else begin
            $display("scaled_font_text_rasterizer_core test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timed out with %0d squares still owed", squares_due.size());
        $display("scaled_font_text_rasterizer_core test failed");
        $finish;
    end

endmodule
